### hdl/crc_checked_command_frame_receiver_macros.svh
// Assertion macros shared by the frame receiver RTL.
`ifndef CRC_CHECKED_COMMAND_FRAME_RECEIVER_MACROS_SVH
`define CRC_CHECKED_COMMAND_FRAME_RECEIVER_MACROS_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define CCFR_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked on every clock edge outside reset.
`define CCFR_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### hdl/ccfr_pkg.sv
// Shared types and constants of the CRC-checked command frame receiver.
`default_nettype none
package ccfr_pkg;

   localparam int BYTE_W    = 8;
   localparam int WORD_W    = 32;
   localparam int CRC_W     = 16;
   localparam int NUM_WORDS = 5;
   localparam int FRAME_LEN = 24;
   localparam int CRC_LEN   = 22;
   localparam int POS_W     = $clog2(FRAME_LEN);

   localparam logic [CRC_W-1:0]  CRC_INIT         = 16'hFFFF;
   localparam logic [BYTE_W-1:0] IDLE_LIMIT_RESET = 8'd50;
   localparam logic [BYTE_W-1:0] HEADER_RESET     = 8'hAA;

   // Word kinds on the request side.
   typedef enum logic {
      OP_BYTE = 1'b0,
      OP_IDLE = 1'b1
   } op_type;

   // Result kinds on the response side.
   typedef enum logic [1:0] {
      KIND_FRAME_OK     = 2'd0,
      KIND_CRC_ERROR    = 2'd1,
      KIND_IDLE_TIMEOUT = 2'd2
   } event_kind_type;

   // Configuration register indexes.
   typedef enum logic {
      REG_IDLE_LIMIT = 1'b0,
      REG_HEADER     = 1'b1
   } csr_addr_type;

endpackage
`default_nettype wire

### hdl/ccfr_crc16.sv
// One-byte update of the reflected Modbus CRC-16.
`default_nettype none
module ccfr_crc16 (
   input  logic [ccfr_pkg::CRC_W-1:0]  crc_in,
   input  logic [ccfr_pkg::BYTE_W-1:0] data_in,
   output logic [ccfr_pkg::CRC_W-1:0]  crc_out
);
   import ccfr_pkg::*;

   localparam logic [CRC_W-1:0] CRC_POLY = 16'hA001;

   logic [CRC_W-1:0] c;

   // Eight shift steps, one per data bit, least significant bit first.
   always_comb begin
      c = crc_in ^ {{(CRC_W-BYTE_W){1'b0}}, data_in};
      for (int k = 0; k < BYTE_W; k++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      crc_out = c;
   end

endmodule
`default_nettype wire

### hdl/crc_checked_command_frame_receiver.sv
// A word is registered on acceptance; its result, if any, is registered when the word is processed.
// Throughput: one word per cycle while results are taken; the input register and the result
// register run in step; while a result waits, the input takes one more word, then stalls.
// The path per word is one CRC-16 byte update (eight shift steps) plus a byte compare.
// Reset is synchronous and active high: control state, the CRC, the idle count, the held mode
// (one) and held words (zero) and both configuration registers return to their defaults.
`default_nettype none
`include "crc_checked_command_frame_receiver_macros.svh"
module crc_checked_command_frame_receiver (
   input  logic                                clock,
   input  logic                                reset,
   // Request stream.
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [ccfr_pkg::BYTE_W-1:0]         req_tdata,  // [7:0] rx_byte
   input  logic                                req_tuser,  // [0] operation
   // Response stream.
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // [7:0] mode_value, [39:8] a_word, [71:40] b_word, [103:72] x_word,
   // [135:104] y_word, [167:136] theta_word
   output logic [ccfr_pkg::BYTE_W+ccfr_pkg::NUM_WORDS*ccfr_pkg::WORD_W-1:0] rsp_tdata,
   output logic [1:0]                          rsp_tuser,  // [1:0] event_kind
   // Configuration write port.
   input  logic                                csr_we,
   input  logic                                csr_addr,
   input  logic [ccfr_pkg::BYTE_W-1:0]         csr_wdata
);
   import ccfr_pkg::*;

   localparam logic [POS_W-1:0] LAST_POS = POS_W'(FRAME_LEN - 1);
   localparam logic [POS_W-1:0] CRC_END  = POS_W'(CRC_LEN);
   localparam logic [POS_W-1:0] CRC_LO   = POS_W'(CRC_LEN);

   // Configuration registers.
   logic [BYTE_W-1:0] idle_limit_ff, idle_limit_in;
   logic [BYTE_W-1:0] header_ff, header_in;

   // Input register: one word waiting to be processed.
   logic              in_valid_ff, in_valid_in;
   op_type            in_op_ff, in_op_in;
   logic [BYTE_W-1:0] in_byte_ff, in_byte_in;

   // Frame state.
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic [CRC_W-1:0]  crc_ff, crc_in;
   logic [BYTE_W-1:0] idle_cnt_ff, idle_cnt_in;
   logic [BYTE_W-1:0] store_ff [FRAME_LEN];
   logic [BYTE_W-1:0] mode_ff, mode_in;
   logic [WORD_W-1:0] words_ff [NUM_WORDS];
   logic [WORD_W-1:0] words_in [NUM_WORDS];

   // Result register. The data part is the held mode and words themselves: they
   // only change when a word is processed, which waits until the result is taken.
   logic              rsp_valid_ff, rsp_valid_in;
   event_kind_type    rsp_kind_ff, rsp_kind_in;

   logic              advance;
   logic              store_we;
   logic [CRC_W-1:0]  crc_src;
   logic [CRC_W-1:0]  crc_next;
   logic [BYTE_W-1:0] idle_inc;
   logic              crc_match;

   // The input word is processed when the result register is free or being emptied.
   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   // A header byte restarts the CRC from its initial value; later bytes continue it.
   assign crc_src = (pos_ff == '0) ? CRC_INIT : crc_ff;

   ccfr_crc16 u_crc (
      .crc_in  (crc_src),
      .data_in (in_byte_ff),
      .crc_out (crc_next)
   );

   assign idle_inc  = idle_cnt_ff + 8'd1;
   // Byte 22 is already stored; byte 23 is the word in hand when the frame closes.
   assign crc_match = (store_ff[CRC_LO] == crc_ff[BYTE_W-1:0])
                      && (in_byte_ff == crc_ff[CRC_W-1:BYTE_W]);

   // Configuration writes.
   always_comb begin
      idle_limit_in = idle_limit_ff;
      header_in     = header_ff;
      if (csr_we) begin
         unique case (csr_addr_type'(csr_addr))
            REG_IDLE_LIMIT: idle_limit_in = csr_wdata;
            REG_HEADER:     header_in     = csr_wdata;
            default: ;
         endcase
      end
   end

   // Input register.
   always_comb begin
      in_valid_in = in_valid_ff;
      in_op_in    = in_op_ff;
      in_byte_in  = in_byte_ff;
      if (req_tready) begin
         in_valid_in = req_tvalid;
         in_op_in    = op_type'(req_tuser);
         in_byte_in  = req_tdata;
      end
   end

   // Frame processing for the word held in the input register.
   always_comb begin
      pos_in       = pos_ff;
      crc_in       = crc_ff;
      idle_cnt_in  = idle_cnt_ff;
      mode_in      = mode_ff;
      store_we     = 1'b0;
      for (int j = 0; j < NUM_WORDS; j++) begin
         words_in[j] = words_ff[j];
      end
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_kind_in  = rsp_kind_ff;

      if (advance) begin
         case (in_op_ff)
            OP_IDLE: begin
               // Idle ticks count only between frames.
               if (pos_ff == '0) begin
                  idle_cnt_in = idle_inc;
                  if (idle_inc == idle_limit_ff) begin
                     idle_cnt_in  = '0;
                     mode_in      = BYTE_W'(1);
                     words_in[0]  = '0;
                     words_in[1]  = '0;
                     rsp_valid_in = 1'b1;
                     rsp_kind_in  = KIND_IDLE_TIMEOUT;
                  end
               end
            end
            default: begin
               idle_cnt_in = '0;
               if (pos_ff == '0) begin
                  // Between frames only the header byte is kept.
                  if (in_byte_ff == header_ff) begin
                     store_we = 1'b1;
                     crc_in   = crc_next;
                     pos_in   = POS_W'(1);
                  end
               end else begin
                  store_we = 1'b1;
                  if (pos_ff < CRC_END) begin
                     crc_in = crc_next;
                  end
                  if (pos_ff == LAST_POS) begin
                     pos_in       = '0;
                     rsp_valid_in = 1'b1;
                     if (crc_match) begin
                        rsp_kind_in = KIND_FRAME_OK;
                        mode_in     = store_ff[1];
                        for (int j = 0; j < NUM_WORDS; j++) begin
                           words_in[j] = {store_ff[2 + 4*j + 3], store_ff[2 + 4*j + 2],
                                          store_ff[2 + 4*j + 1], store_ff[2 + 4*j]};
                        end
                     end else begin
                        rsp_kind_in = KIND_CRC_ERROR;
                     end
                  end else begin
                     pos_in = pos_ff + POS_W'(1);
                  end
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idle_limit_ff <= IDLE_LIMIT_RESET;
         header_ff     <= HEADER_RESET;
         in_valid_ff   <= 1'b0;
         pos_ff        <= '0;
         crc_ff        <= CRC_INIT;
         idle_cnt_ff   <= '0;
         mode_ff       <= BYTE_W'(1);
         for (int j = 0; j < NUM_WORDS; j++) begin
            words_ff[j] <= '0;
         end
         rsp_valid_ff  <= 1'b0;
         rsp_kind_ff   <= KIND_FRAME_OK;
      end else begin
         idle_limit_ff <= idle_limit_in;
         header_ff     <= header_in;
         in_valid_ff   <= in_valid_in;
         pos_ff        <= pos_in;
         crc_ff        <= crc_in;
         idle_cnt_ff   <= idle_cnt_in;
         mode_ff       <= mode_in;
         for (int j = 0; j < NUM_WORDS; j++) begin
            words_ff[j] <= words_in[j];
         end
         rsp_valid_ff  <= rsp_valid_in;
         rsp_kind_ff   <= rsp_kind_in;
      end
   end

   // Payload registers need no reset: the frame store is only read after the
   // current frame has written the bytes in question.
   always_ff @(posedge clock) begin
      in_op_ff   <= in_op_in;
      in_byte_ff <= in_byte_in;
      if (store_we) begin
         store_ff[pos_ff] <= in_byte_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tdata  = {words_ff[4], words_ff[3], words_ff[2], words_ff[1], words_ff[0], mode_ff};

   `CCFR_ASSERT_NOW(a_pos_in_range, 1'b1, pos_ff <= LAST_POS,
      "frame position ran past the last byte")
   `CCFR_ASSERT_NOW(a_no_idle_in_frame, pos_ff != '0, idle_cnt_ff == '0,
      "idle count nonzero inside a frame")
   `CCFR_ASSERT_NOW(a_timeout_values, rsp_valid_ff && (rsp_kind_ff == KIND_IDLE_TIMEOUT),
      (mode_ff == BYTE_W'(1)) && (words_ff[0] == '0) && (words_ff[1] == '0),
      "timeout result does not show the cleared mode and speeds")
   `CCFR_ASSERT_NEXT(a_frame_close, advance && (in_op_ff == OP_BYTE) && (pos_ff == LAST_POS),
      rsp_valid_ff && (pos_ff == '0), "closing byte of a frame gave no result")

endmodule
`default_nettype wire

### tb/tb_crc_checked_command_frame_receiver.sv
// Self-checking testbench for the CRC-checked command frame receiver.
`default_nettype none
module tb_crc_checked_command_frame_receiver;
   import ccfr_pkg::*;

   // The run ends with a failure if it has not finished after this many cycles.
   localparam int CYCLE_LIMIT = 400000;
   // Longest wait for outstanding results once the sender has gone quiet.
   localparam int DRAIN_LIMIT = 5000;
   // The block registers a result once the word is processed; the settle wait covers
   // words that produce no result before a register write.
   localparam int SETTLE_CYCLES = 4;
   localparam logic [CRC_W-1:0] CRC_POLY = 16'hA001;
   localparam int RSP_W = BYTE_W + NUM_WORDS * WORD_W;

   // One serial word on the request side: a byte or an idle tick.
   typedef struct packed {
      op_type             op;
      logic [BYTE_W-1:0]  data;
   } serial_word_t;

   // One reported event together with the held mode and words that go with it.
   typedef struct packed {
      event_kind_type                        kind;
      logic [BYTE_W-1:0]                     mode;
      logic [NUM_WORDS-1:0][WORD_W-1:0]      words;
   } frame_event_t;

   typedef logic [BYTE_W-1:0] frame_image_t [FRAME_LEN];

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic               req_tvalid = 1'b0;
   logic               req_tready;
   logic [BYTE_W-1:0]  req_tdata = '0;     // [7:0] rx_byte
   logic               req_tuser = 1'b0;   // [0] operation
   logic               rsp_tvalid;
   logic               rsp_tready = 1'b0;
   // [7:0] mode_value, [39:8] a_word, [71:40] b_word, [103:72] x_word,
   // [135:104] y_word, [167:136] theta_word
   logic [RSP_W-1:0]   rsp_tdata;
   logic [1:0]         rsp_tuser;          // [1:0] event_kind
   logic               csr_we = 1'b0;
   logic               csr_addr = 1'b0;
   logic [BYTE_W-1:0]  csr_wdata = '0;

   crc_checked_command_frame_receiver dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always #5 clock = ~clock;

   // Words waiting to be sent and events the receiver must still report.
   serial_word_t pending_words [$];
   frame_event_t expected_events [$];

   int error_count = 0;
   int cycle_count = 0;
   int queued_count = 0;
   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   // Set at each rising edge when the request word on the bus was taken.
   bit req_taken = 1'b0;

   // Our own copy of the receiver state. The configuration copies are also
   // what the stimulus uses to build frames with the current header.
   logic [BYTE_W-1:0] idle_limit_cfg = IDLE_LIMIT_RESET;
   logic [BYTE_W-1:0] header_cfg = HEADER_RESET;
   int                frame_pos = 0;
   logic [CRC_W-1:0]  crc_acc = CRC_INIT;
   logic [BYTE_W-1:0] frame_bytes [FRAME_LEN];
   logic [BYTE_W-1:0] idle_ticks = '0;
   logic [BYTE_W-1:0] mode_hold = 8'd1;
   logic [WORD_W-1:0] word_hold [NUM_WORDS] = '{default: '0};

   string word_field [NUM_WORDS] = '{"a_word", "b_word", "x_word", "y_word", "theta_word"};

   // Modbus CRC-16 update by one byte, least significant bit first.
   function automatic logic [CRC_W-1:0] crc16_byte(logic [CRC_W-1:0] acc,
                                                   logic [BYTE_W-1:0] b);
      logic [CRC_W-1:0] c;
      c = acc ^ {8'h00, b};
      for (int k = 0; k < 8; k++)
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      return c;
   endfunction

   function automatic void post_event(event_kind_type kind);
      frame_event_t ev;
      ev.kind = kind;
      ev.mode = mode_hold;
      for (int j = 0; j < NUM_WORDS; j++)
         ev.words[j] = word_hold[j];
      expected_events.push_back(ev);
   endfunction

   // Advances the receiver copy by one accepted word and records any event it causes.
   function automatic void advance_receiver(serial_word_t w);
      if (w.op == OP_IDLE) begin
         // Idle ticks only count between frames; inside a frame they are ignored.
         if (frame_pos != 0)
            return;
         idle_ticks = idle_ticks + 8'd1;
         if (idle_ticks == idle_limit_cfg) begin
            idle_ticks = '0;
            mode_hold = 8'd1;
            word_hold[0] = '0;
            word_hold[1] = '0;
            post_event(KIND_IDLE_TIMEOUT);
         end
         return;
      end
      idle_ticks = '0;
      if (frame_pos == 0) begin
         // Between frames only the header byte matters; anything else is dropped.
         if (w.data == header_cfg) begin
            frame_bytes[0] = w.data;
            crc_acc = crc16_byte(CRC_INIT, w.data);
            frame_pos = 1;
         end
         return;
      end
      frame_bytes[frame_pos] = w.data;
      if (frame_pos < CRC_LEN)
         crc_acc = crc16_byte(crc_acc, w.data);
      frame_pos++;
      if (frame_pos < FRAME_LEN)
         return;
      frame_pos = 0;
      if ({frame_bytes[FRAME_LEN-1], frame_bytes[FRAME_LEN-2]} == crc_acc) begin
         mode_hold = frame_bytes[1];
         for (int j = 0; j < NUM_WORDS; j++)
            word_hold[j] = {frame_bytes[5+4*j], frame_bytes[4+4*j],
                            frame_bytes[3+4*j], frame_bytes[2+4*j]};
         post_event(KIND_FRAME_OK);
      end else begin
         post_event(KIND_CRC_ERROR);
      end
   endfunction

   function automatic void queue_word(op_type op, logic [BYTE_W-1:0] data);
      serial_word_t w;
      w.op = op;
      w.data = data;
      pending_words.push_back(w);
      queued_count++;
   endfunction

   // Random byte leaning toward the extremes and the current header value.
   function automatic logic [BYTE_W-1:0] rand_byte();
      case ($urandom_range(9))
         0: return 8'h00;
         1: return 8'hFF;
         2: return header_cfg;
         default: return BYTE_W'($urandom_range(255));
      endcase
   endfunction

   // Queues a full frame whose bytes 1..21 the caller has filled. The header and
   // the checksum are put in here; a bad frame has one checksum byte corrupted.
   // Idle ticks may be slipped in somewhere after the header.
   function automatic void queue_frame(frame_image_t fb, bit good, int idle_inside);
      logic [CRC_W-1:0] crc;
      int spot;
      int pick;
      fb[0] = header_cfg;
      crc = CRC_INIT;
      for (int i = 0; i < CRC_LEN; i++)
         crc = crc16_byte(crc, fb[i]);
      fb[CRC_LEN] = crc[7:0];
      fb[CRC_LEN+1] = crc[15:8];
      if (!good) begin
         pick = CRC_LEN + $urandom_range(1);
         fb[pick] = fb[pick] ^ BYTE_W'($urandom_range(1, 255));
      end
      spot = (idle_inside > 0) ? $urandom_range(1, FRAME_LEN - 1) : FRAME_LEN;
      for (int i = 0; i < FRAME_LEN; i++) begin
         if (i == spot)
            repeat (idle_inside) queue_word(OP_IDLE, rand_byte());
         queue_word(OP_BYTE, fb[i]);
      end
   endfunction

   // Random traffic: mostly well-formed frames with random content, plus idle
   // runs, some long enough to time out, stray bytes and frames cut short.
   function automatic void queue_traffic(int budget);
      frame_image_t fb;
      int stop_at;
      int pick;
      int run_len;
      stop_at = queued_count + budget;
      while (queued_count < stop_at) begin
         pick = $urandom_range(99);
         for (int i = 1; i < CRC_LEN; i++)
            fb[i] = rand_byte();
         if (pick < 55) begin
            queue_frame(fb, 1'b1, ($urandom_range(3) == 0) ? $urandom_range(1, 3) : 0);
         end else if (pick < 70) begin
            queue_frame(fb, 1'b0, ($urandom_range(5) == 0) ? 1 : 0);
         end else if (pick < 85) begin
            // Either enough ticks to reach the limit or a short run.
            if ($urandom_range(2) == 0)
               run_len = int'(idle_limit_cfg) + $urandom_range(0, 2);
            else
               run_len = $urandom_range(1, 20);
            repeat (run_len) queue_word(OP_IDLE, BYTE_W'($urandom_range(255)));
         end else if (pick < 95) begin
            repeat ($urandom_range(1, 4)) queue_word(OP_BYTE, BYTE_W'($urandom_range(255)));
         end else begin
            // A frame cut short: whatever follows is taken in as its remaining bytes.
            queue_word(OP_BYTE, header_cfg);
            for (int i = 1; i <= $urandom_range(0, CRC_LEN - 1); i++)
               queue_word(OP_BYTE, fb[i]);
         end
      end
   endfunction

   // Short hand-built opening: dropped bytes and idle ticks at the data extremes,
   // then one good frame with all-ones and all-zeros words, header-valued bytes
   // inside the frame and an idle tick that must be ignored.
   function automatic void queue_directed();
      frame_image_t fb;
      queue_word(OP_BYTE, 8'h00);
      queue_word(OP_BYTE, 8'hFF);
      queue_word(OP_IDLE, 8'hFF);
      queue_word(OP_IDLE, 8'h00);
      fb[1] = 8'hFF;
      for (int i = 2; i < 6; i++) fb[i] = 8'hFF;
      for (int i = 6; i < 10; i++) fb[i] = 8'h00;
      for (int i = 10; i < 14; i++) fb[i] = header_cfg;
      {fb[17], fb[16], fb[15], fb[14]} = 32'h8000_0001;
      {fb[21], fb[20], fb[19], fb[18]} = 32'h7FFF_FFFE;
      queue_frame(fb, 1'b1, 1);
   endfunction

   // Registers are only written while nothing is in flight, so the copy can be
   // updated at once.
   task automatic write_reg(csr_addr_type idx, logic [BYTE_W-1:0] value);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_addr <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
      if (idx == REG_IDLE_LIMIT)
         idle_limit_cfg = value;
      else
         header_cfg = value;
   endtask

   // Waits until every queued word has gone and every expected event has been
   // reported or the drain limit runs out, then lets the block settle.
   task automatic wait_until_drained();
      int waited;
      waited = 0;
      while (pending_words.size() != 0 || req_tvalid)
         @(posedge clock);
      while (expected_events.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      if (expected_events.size() != 0) begin
         $error("%0d expected events never reported", expected_events.size());
         error_count++;
         expected_events.delete();
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // One phase: set the idling mix, queue half the traffic, pause until all of
   // it is answered, then the other half and another full drain.
   task automatic run_phase(int send_pct, int stall_pct, int budget);
      send_idle_pct = send_pct;
      rsp_stall_pct = stall_pct;
      queue_traffic(budget / 2);
      wait_until_drained();
      queue_traffic(budget - budget / 2);
      wait_until_drained();
   endtask

   // Sequencer: reset, then phases with different register settings and idling.
   initial begin
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset defaults first, with a steady sender and receiver.
      queue_directed();
      run_phase(0, 0, 350);

      // Shortest idle limit: every idle tick between frames times out.
      write_reg(REG_IDLE_LIMIT, 8'd1);
      write_reg(REG_HEADER, 8'h00);
      run_phase(64, 0, 380);

      write_reg(REG_IDLE_LIMIT, 8'd255);
      write_reg(REG_HEADER, 8'hFF);
      run_phase(0, 64, 380);

      write_reg(REG_IDLE_LIMIT, BYTE_W'($urandom_range(2, 40)));
      write_reg(REG_HEADER, BYTE_W'($urandom_range(1, 254)));
      run_phase(24, 24, 380);

      if (error_count == 0)
         $display("[crc_checked_command_frame_receiver] OK");
      else
         $display("[crc_checked_command_frame_receiver] ERROR");
      $finish;
   end

   // Driver: a new word goes on the bus once the previous one was taken, unless
   // the sender decides to idle this cycle.
   always @(negedge clock) begin
      serial_word_t next_word;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_taken) begin
         if (pending_words.size() == 0 || $urandom_range(99) < send_idle_pct) begin
            req_tvalid <= 1'b0;
         end else begin
            next_word = pending_words.pop_front();
            req_tvalid <= 1'b1;
            req_tuser <= next_word.op;
            req_tdata <= next_word.data;
         end
      end
      rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   // Monitor: check the reported event against the oldest expectation first,
   // since a word taken at this edge can only be answered at a later one.
   always @(posedge clock) begin
      frame_event_t due;
      serial_word_t taken;
      req_taken = !reset && req_tvalid && req_tready;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_events.size() == 0) begin
            $error("unexpected event: event_kind %0d mode_value %0h", rsp_tuser, rsp_tdata[7:0]);
            error_count++;
         end else begin
            due = expected_events.pop_front();
            if (rsp_tuser !== due.kind) begin
               $error("event_kind: expected %0d, got %0d", due.kind, rsp_tuser);
               error_count++;
            end
            if (rsp_tdata[BYTE_W-1:0] !== due.mode) begin
               $error("mode_value: expected %0h, got %0h", due.mode, rsp_tdata[BYTE_W-1:0]);
               error_count++;
            end
            for (int j = 0; j < NUM_WORDS; j++) begin
               if (rsp_tdata[BYTE_W+WORD_W*j +: WORD_W] !== due.words[j]) begin
                  $error("%s: expected %08h, got %08h", word_field[j], due.words[j],
                         rsp_tdata[BYTE_W+WORD_W*j +: WORD_W]);
                  error_count++;
               end
            end
         end
      end
      if (req_taken) begin
         taken.op = op_type'(req_tuser);
         taken.data = req_tdata;
         advance_receiver(taken);
      end
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("[crc_checked_command_frame_receiver] ERROR");
         $finish;
      end
   end

endmodule
`default_nettype wire

### crc_checked_command_frame_receiver.f
+incdir+hdl
hdl/ccfr_pkg.sv
hdl/ccfr_crc16.sv
hdl/crc_checked_command_frame_receiver.sv
tb/tb_crc_checked_command_frame_receiver.sv
